// ===== hdl/efd_pkg.sv =====
package efd_pkg;

    // Counter width used when the top level is not overridden
    localparam int COUNT_WIDTH_DEF = 32;

    // Width of the configuration register index
    localparam int CFG_INDEX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_VALUE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_SHORT_AC  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_SHORT_S   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_LONG_S    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TYPE_STATUS    = 3'd4;

    // Register reset values
    localparam logic [7:0] SYNC_VALUE_RST    = 8'd26;
    localparam logic [7:0] TYPE_SHORT_AC_RST = 8'd49;
    localparam logic [7:0] TYPE_SHORT_S_RST  = 8'd50;
    localparam logic [7:0] TYPE_LONG_S_RST   = 8'd51;
    localparam logic [7:0] TYPE_STATUS_RST   = 8'd52;

    // Frame layout
    localparam int HEADER_LEN      = 7;
    localparam int PAYLOAD_AC      = 2;
    localparam int PAYLOAD_SHORT_S = 7;
    localparam int PAYLOAD_LONG_S  = 14;

    // Entries in the queue between parser and output stage (power of two)
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        EV_DATA      = 2'd0,
        EV_SYNC      = 2'd1,
        EV_TYPE      = 2'd2,
        EV_SYNC_TYPE = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        KIND_AC      = 2'd0,
        KIND_SHORT_S = 2'd1,
        KIND_LONG_S  = 2'd2,
        KIND_STATUS  = 2'd3
    } t_kind;

    // One result as it travels from the parser to the output stage
    typedef struct packed {
        t_event     ev_code;
        t_kind      kind;
        logic [4:0] idx;
        logic [7:0] data;
        logic       done;
    } t_entry;

    // Index of the final body byte of a frame of the given kind
    function automatic logic [4:0] last_index(input t_kind kind);
        logic [4:0] res;
        case (kind)
            KIND_AC:      res = 5'(HEADER_LEN + PAYLOAD_AC - 1);
            KIND_SHORT_S: res = 5'(HEADER_LEN + PAYLOAD_SHORT_S - 1);
            KIND_LONG_S:  res = 5'(HEADER_LEN + PAYLOAD_LONG_S - 1);
            KIND_STATUS:  res = 5'(HEADER_LEN + PAYLOAD_LONG_S - 1);
            default:      res = 5'(HEADER_LEN + PAYLOAD_LONG_S - 1);
        endcase
        return res;
    endfunction

endpackage

// ===== hdl/efd_byte_if.sv =====
interface efd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/efd_result_if.sv =====
interface efd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [1:0]  frame_kind;
    logic [4:0]  byte_index;
    logic [7:0]  data_value;
    logic        frame_done;
    logic [31:0] sync_error_count;
    logic [31:0] bad_type_count;

    modport source (
        output valid, output event_res, output frame_kind, output byte_index,
        output data_value, output frame_done, output sync_error_count,
        output bad_type_count, input ready
    );
    modport sink (
        input valid, input event_res, input frame_kind, input byte_index,
        input data_value, input frame_done, input sync_error_count,
        input bad_type_count, output ready
    );
endinterface

// ===== hdl/efd_cfg_if.sv =====
interface efd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [efd_pkg::CFG_INDEX_W-1:0]  index;
    logic [7:0]                       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/efd_front.sv =====
module efd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    efd_byte_if.sink          i_in,
    efd_cfg_if.sink           i_cfg,
    input  logic              i_q_full,
    output logic              o_push,
    output efd_pkg::t_entry   o_push_data
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_HUNT,
        MODE_HUNT_PEEK,
        MODE_TYPE,
        MODE_BODY,
        MODE_BODY_ESC
    } t_mode;

    t_mode           r_mode, n_mode;
    logic [4:0]      r_pos, n_pos;
    efd_pkg::t_kind  r_kind, n_kind;

    logic [7:0]      r_sync, r_ty_ac, r_ty_ss, r_ty_ls, r_ty_st;

    logic            accept;
    logic            is_sync;
    logic            type_hit;
    efd_pkg::t_kind  type_kind;
    logic            do_type;
    logic            do_body;
    logic            pending;
    logic            emit;
    efd_pkg::t_entry entry;

    // Configuration writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync  <= efd_pkg::SYNC_VALUE_RST;
            r_ty_ac <= efd_pkg::TYPE_SHORT_AC_RST;
            r_ty_ss <= efd_pkg::TYPE_SHORT_S_RST;
            r_ty_ls <= efd_pkg::TYPE_LONG_S_RST;
            r_ty_st <= efd_pkg::TYPE_STATUS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                efd_pkg::REG_SYNC_VALUE:    r_sync  <= i_cfg.data;
                efd_pkg::REG_TYPE_SHORT_AC: r_ty_ac <= i_cfg.data;
                efd_pkg::REG_TYPE_SHORT_S:  r_ty_ss <= i_cfg.data;
                efd_pkg::REG_TYPE_LONG_S:   r_ty_ls <= i_cfg.data;
                efd_pkg::REG_TYPE_STATUS:   r_ty_st <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Take a byte whenever the queue has room
    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    // Classify the byte against sync and the type codes, in register order
    always_comb begin
        is_sync   = (i_in.rx_byte == r_sync);
        type_hit  = 1'b1;
        type_kind = efd_pkg::KIND_AC;
        if (i_in.rx_byte == r_ty_ac) begin
            type_kind = efd_pkg::KIND_AC;
        end else if (i_in.rx_byte == r_ty_ss) begin
            type_kind = efd_pkg::KIND_SHORT_S;
        end else if (i_in.rx_byte == r_ty_ls) begin
            type_kind = efd_pkg::KIND_LONG_S;
        end else if (i_in.rx_byte == r_ty_st) begin
            type_kind = efd_pkg::KIND_STATUS;
        end else begin
            type_hit = 1'b0;
        end
    end

    // Next parse state and the result this byte produces
    always_comb begin
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_kind  = r_kind;
        do_type = 1'b0;
        do_body = 1'b0;
        pending = 1'b0;
        emit    = 1'b0;
        entry   = '{ev_code: efd_pkg::EV_SYNC, kind: efd_pkg::KIND_AC,
                    idx: 5'd0, data: 8'd0, done: 1'b0};

        case (r_mode)
            MODE_HUNT: begin
                if (is_sync) n_mode = MODE_HUNT_PEEK;
            end
            MODE_HUNT_PEEK: begin
                if (is_sync) n_mode = MODE_HUNT;
                else         do_type = 1'b1;
            end
            MODE_TYPE: begin
                do_type = 1'b1;
            end
            MODE_BODY: begin
                if (is_sync) n_mode = MODE_BODY_ESC;
                else         do_body = 1'b1;
            end
            MODE_BODY_ESC: begin
                if (is_sync) begin
                    do_body = 1'b1;
                end else begin
                    do_type = 1'b1;
                    pending = 1'b1;
                end
            end
            default: begin
                if (is_sync) begin
                    n_mode = MODE_TYPE;
                end else begin
                    emit   = 1'b1;
                    n_mode = MODE_HUNT;
                end
            end
        endcase

        // Type byte: start a body, or report and hunt
        if (do_type) begin
            if (is_sync) begin
                emit   = 1'b1;
                n_mode = MODE_HUNT;
            end else if (type_hit) begin
                n_kind = type_kind;
                n_pos  = 5'd0;
                n_mode = MODE_BODY;
                emit   = pending;
            end else begin
                emit          = 1'b1;
                entry.ev_code = pending ? efd_pkg::EV_SYNC_TYPE : efd_pkg::EV_TYPE;
                n_mode        = MODE_HUNT;
            end
        end

        // Body byte: emit it and advance the position
        if (do_body) begin
            emit          = 1'b1;
            entry.ev_code = efd_pkg::EV_DATA;
            entry.kind    = r_kind;
            entry.idx     = r_pos;
            entry.data    = i_in.rx_byte;
            entry.done    = (r_pos >= efd_pkg::last_index(r_kind));
            if (entry.done) begin
                n_mode = MODE_IDLE;
                n_pos  = 5'd0;
            end else begin
                n_mode = MODE_BODY;
                n_pos  = r_pos + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_pos  <= 5'd0;
            r_kind <= efd_pkg::KIND_AC;
        end else if (accept) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_kind <= n_kind;
        end
    end

    assign o_push      = accept && emit;
    assign o_push_data = entry;

endmodule

// ===== hdl/efd_queue.sv =====
module efd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  efd_pkg::t_entry i_push_data,
    output logic            o_full,
    output logic            o_valid,
    output efd_pkg::t_entry o_head,
    input  logic            i_pop
);

    localparam int PTR_W = (efd_pkg::QUEUE_DEPTH > 1) ? $clog2(efd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(efd_pkg::QUEUE_DEPTH + 1);

    efd_pkg::t_entry  r_mem [efd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CNT_W'(efd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store the incoming entry
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_push_data;
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + PTR_W'(1);
            if (do_pop)  r_rd <= r_rd + PTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/efd_back.sv =====
module efd_back #(
    parameter int COUNT_WIDTH = efd_pkg::COUNT_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  efd_pkg::t_entry i_q_head,
    output logic            o_pop,
    efd_result_if.source    o_out
);

    logic                   r_valid;
    efd_pkg::t_entry        r_entry;
    logic [COUNT_WIDTH-1:0] r_sync_cnt;
    logic [COUNT_WIDTH-1:0] r_type_cnt;

    logic load;
    logic inc_sync;
    logic inc_type;

    // Load the next entry when the output register is free or being taken
    assign load  = i_q_valid && (!r_valid || o_out.ready);
    assign o_pop = load;

    // Error counters follow the event code
    always_comb begin
        inc_sync = i_q_head.ev_code inside {efd_pkg::EV_SYNC, efd_pkg::EV_SYNC_TYPE};
        inc_type = i_q_head.ev_code inside {efd_pkg::EV_TYPE, efd_pkg::EV_SYNC_TYPE};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_sync_cnt <= '0;
            r_type_cnt <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                if (inc_sync) r_sync_cnt <= r_sync_cnt + COUNT_WIDTH'(1);
                if (inc_type) r_type_cnt <= r_type_cnt + COUNT_WIDTH'(1);
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload until transfer
    always_ff @(posedge i_clk) begin
        if (load) r_entry <= i_q_head;
    end

    assign o_out.valid            = r_valid;
    assign o_out.event_res        = r_entry.ev_code;
    assign o_out.frame_kind       = r_entry.kind;
    assign o_out.byte_index       = r_entry.idx;
    assign o_out.data_value       = r_entry.data;
    assign o_out.frame_done       = r_entry.done;
    assign o_out.sync_error_count = 32'(r_sync_cnt);
    assign o_out.bad_type_count   = 32'(r_type_cnt);

endmodule

// ===== hdl/escaped_frame_deframer.sv =====
// Escaped frame deframer.
// i_in carries one raw link byte per transfer; i_cfg writes the sync byte
// (index 0) and the four type codes (indexes 1 to 4) and is always ready.
// o_out carries one result per emitted body byte or error event: the
// event code, frame kind, body index, unescaped data, a done flag on the
// last byte of a complete frame, and both running error counts.
// Bytes that produce no result (leading sync, type byte, hunted bytes, the
// first sync of an escape pair) are consumed without output.
// Throughput: one byte per cycle, sustained while the queue has room; the
// parser classifies and updates its state within the cycle of the transfer.
// A result reaches o_out through one queue stage and one output register
// after its byte's transfer.
// Reset returns the parser to waiting for a frame sync, clears the error
// counters and restores the register defaults.
// When the receiver stalls, the output register holds its result and a
// two-entry queue absorbs further results; i_in.ready drops once the queue
// is full, and rises again as o_out drains.
module escaped_frame_deframer #(
    parameter int COUNT_WIDTH = efd_pkg::COUNT_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    efd_byte_if.sink     i_in,
    efd_cfg_if.sink      i_cfg,
    efd_result_if.source o_out
);

    logic            q_full;
    logic            q_push;
    efd_pkg::t_entry q_push_data;
    logic            q_valid;
    efd_pkg::t_entry q_head;
    logic            q_pop;

    efd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    efd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_head      (q_head),
        .i_pop       (q_pop)
    );

    efd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

// ===== verif/escaped_frame_deframer_test.sv =====
`timescale 1ns / 1ps

module escaped_frame_deframer_test;

    // Parser states of the byte-level predictor
    typedef enum {
        PM_WAIT_SYNC,
        PM_HUNT,
        PM_HUNT_PEEK,
        PM_WAIT_TYPE,
        PM_BODY,
        PM_BODY_ESC
    } t_parse_mode;

    // One deframed result as it should leave the block
    typedef struct {
        efd_pkg::t_event ev;
        efd_pkg::t_kind  kind;
        logic [4:0]      idx;
        logic [7:0]      data;
        logic            done;
        logic [31:0]     sync_cnt;
        logic [31:0]     type_cnt;
    } t_deframed;

    logic i_clk;
    logic i_rst_n;

    efd_byte_if   in_bus ();
    efd_cfg_if    cfg_bus ();
    efd_result_if out_bus ();

    escaped_frame_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (out_bus)
    );

    // Predictor registers and parser state
    logic [7:0]     reg_sync;
    logic [7:0]     reg_code_ac;
    logic [7:0]     reg_code_short_s;
    logic [7:0]     reg_code_long_s;
    logic [7:0]     reg_code_status;
    t_parse_mode    mode;
    logic [4:0]     body_pos;
    efd_pkg::t_kind cur_kind;
    logic [31:0]    sync_errs;
    logic [31:0]    type_errs;

    t_deframed expected_q[$];

    // Stimulus control and run statistics
    bit sender_idle;
    bit receiver_idle;
    bit in_valid_high;
    int next_gap;
    int bytes_sent;
    int mismatch_count;
    int frames_done;
    int error_events;
    int settings_applied;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #5000000;
        $display("Regression FAIL");
        $display("Timed out with %0d results outstanding", expected_q.size());
        $finish;
    end

    function automatic int body_length(input efd_pkg::t_kind kind);
        int payload;
        case (kind)
            efd_pkg::KIND_AC:      payload = efd_pkg::PAYLOAD_AC;
            efd_pkg::KIND_SHORT_S: payload = efd_pkg::PAYLOAD_SHORT_S;
            default:               payload = efd_pkg::PAYLOAD_LONG_S;
        endcase
        return efd_pkg::HEADER_LEN + payload;
    endfunction

    function automatic logic [7:0] type_code_of(input efd_pkg::t_kind kind);
        logic [7:0] code;
        case (kind)
            efd_pkg::KIND_AC:      code = reg_code_ac;
            efd_pkg::KIND_SHORT_S: code = reg_code_short_s;
            efd_pkg::KIND_LONG_S:  code = reg_code_long_s;
            default:               code = reg_code_status;
        endcase
        return code;
    endfunction

    function automatic void set_register(input logic [efd_pkg::CFG_INDEX_W-1:0] idx,
                                         input logic [7:0] value);
        case (idx)
            efd_pkg::REG_SYNC_VALUE:    reg_sync = value;
            efd_pkg::REG_TYPE_SHORT_AC: reg_code_ac = value;
            efd_pkg::REG_TYPE_SHORT_S:  reg_code_short_s = value;
            efd_pkg::REG_TYPE_LONG_S:   reg_code_long_s = value;
            efd_pkg::REG_TYPE_STATUS:   reg_code_status = value;
            default:                    ;
        endcase
    endfunction

    function automatic void reset_predictor();
        reg_sync         = efd_pkg::SYNC_VALUE_RST;
        reg_code_ac      = efd_pkg::TYPE_SHORT_AC_RST;
        reg_code_short_s = efd_pkg::TYPE_SHORT_S_RST;
        reg_code_long_s  = efd_pkg::TYPE_LONG_S_RST;
        reg_code_status  = efd_pkg::TYPE_STATUS_RST;
        mode      = PM_WAIT_SYNC;
        body_pos  = 5'd0;
        cur_kind  = efd_pkg::KIND_AC;
        sync_errs = 32'd0;
        type_errs = 32'd0;
    endfunction

    // Queue one result, stamped with the counts as they stand now
    function automatic void expect_result(input efd_pkg::t_event ev,
                                          input efd_pkg::t_kind kind,
                                          input logic [4:0] idx,
                                          input logic [7:0] data,
                                          input logic done);
        t_deframed r;
        r.ev       = ev;
        r.kind     = kind;
        r.idx      = idx;
        r.data     = data;
        r.done     = done;
        r.sync_cnt = sync_errs;
        r.type_cnt = type_errs;
        expected_q.push_back(r);
    endfunction

    function automatic void expect_error(input efd_pkg::t_event ev);
        expect_result(ev, efd_pkg::KIND_AC, 5'd0, 8'd0, 1'b0);
    endfunction

    // Interpret a byte as frame type; aborted marks a just-counted abort
    function automatic void resolve_type(input logic [7:0] b, input bit aborted);
        efd_pkg::t_kind kind;
        bit             known;
        known = 1'b1;
        kind  = efd_pkg::KIND_AC;
        if (b == reg_sync) begin
            sync_errs = sync_errs + 1;
            mode = PM_HUNT;
            expect_error(efd_pkg::EV_SYNC);
        end else begin
            if (b == reg_code_ac) kind = efd_pkg::KIND_AC;
            else if (b == reg_code_short_s) kind = efd_pkg::KIND_SHORT_S;
            else if (b == reg_code_long_s) kind = efd_pkg::KIND_LONG_S;
            else if (b == reg_code_status) kind = efd_pkg::KIND_STATUS;
            else known = 1'b0;
            if (known) begin
                cur_kind = kind;
                body_pos = 5'd0;
                mode = PM_BODY;
                if (aborted) expect_error(efd_pkg::EV_SYNC);
            end else begin
                type_errs = type_errs + 1;
                mode = PM_HUNT;
                expect_error(aborted ? efd_pkg::EV_SYNC_TYPE : efd_pkg::EV_TYPE);
            end
        end
    endfunction

    function automatic void accept_body_byte(input logic [7:0] b);
        logic done;
        done = (int'(body_pos) >= body_length(cur_kind) - 1);
        expect_result(efd_pkg::EV_DATA, cur_kind, body_pos, b, done);
        if (done) begin
            mode = PM_WAIT_SYNC;
            body_pos = 5'd0;
        end else begin
            mode = PM_BODY;
            body_pos = body_pos + 5'd1;
        end
    endfunction

    // Advance the predictor by one accepted link byte
    function automatic void predict_byte(input logic [7:0] b);
        bit is_sync;
        is_sync = (b == reg_sync);
        case (mode)
            PM_HUNT: begin
                if (is_sync) mode = PM_HUNT_PEEK;
            end
            PM_HUNT_PEEK: begin
                if (is_sync) mode = PM_HUNT;
                else resolve_type(b, 1'b0);
            end
            PM_WAIT_TYPE: resolve_type(b, 1'b0);
            PM_BODY: begin
                if (is_sync) mode = PM_BODY_ESC;
                else accept_body_byte(b);
            end
            PM_BODY_ESC: begin
                if (is_sync) begin
                    accept_body_byte(b);
                end else begin
                    sync_errs = sync_errs + 1;
                    resolve_type(b, 1'b1);
                end
            end
            default: begin
                if (is_sync) begin
                    mode = PM_WAIT_TYPE;
                end else begin
                    sync_errs = sync_errs + 1;
                    mode = PM_HUNT;
                    expect_error(efd_pkg::EV_SYNC);
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_deframed want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected, data", 32'(out_bus.data_value),
                                32'd0);
            end else begin
                want = expected_q.pop_front();
                compare_field("event_res", 32'(out_bus.event_res), 32'(want.ev));
                compare_field("frame_kind", 32'(out_bus.frame_kind), 32'(want.kind));
                compare_field("byte_index", 32'(out_bus.byte_index), 32'(want.idx));
                compare_field("data_value", 32'(out_bus.data_value), 32'(want.data));
                compare_field("frame_done", 32'(out_bus.frame_done), 32'(want.done));
                compare_field("sync_error_count", out_bus.sync_error_count, want.sync_cnt);
                compare_field("bad_type_count", out_bus.bad_type_count, want.type_cnt);
                if (want.done) frames_done++;
                if (want.ev != efd_pkg::EV_DATA) error_events++;
            end
        end
    end

    // Receiver: stall a random number of cycles after each transfer while receiver_idle is set
    initial begin : drain_results
        int stall;
        out_bus.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        out_bus.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (out_bus.valid && out_bus.ready) begin
                stall = receiver_idle ? $urandom_range(0, 8) : 0;
                if (stall > 0) begin
                    out_bus.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    out_bus.ready <= 1'b1;
                end
            end
        end
    end

    // Transfer one link byte; hold valid when the next byte follows at once
    task automatic send_byte(input logic [7:0] value);
        if (next_gap > 0) repeat (next_gap) @(posedge i_clk);
        in_bus.valid   <= 1'b1;
        in_bus.rx_byte <= value;
        in_valid_high = 1'b1;
        do @(posedge i_clk); while (!in_bus.ready);
        predict_byte(value);
        bytes_sent++;
        next_gap = sender_idle ? $urandom_range(0, 8) : 0;
        if (next_gap > 0) begin
            in_bus.valid <= 1'b0;
            in_valid_high = 1'b0;
        end
    endtask

    task automatic release_input();
        if (in_valid_high) begin
            in_bus.valid <= 1'b0;
            in_valid_high = 1'b0;
        end
        next_gap = 0;
    endtask

    // Hold until every expected result has drained or the guard runs out, then let the pipe settle
    task automatic wait_drained();
        int guard;
        guard = 0;
        while (expected_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Write all five registers back to back while the block is idle
    task automatic apply_codes(input logic [7:0] sync_v, input logic [7:0] ac_v,
                               input logic [7:0] short_v, input logic [7:0] long_v,
                               input logic [7:0] status_v);
        logic [efd_pkg::CFG_INDEX_W-1:0] idx_list [5];
        logic [7:0]                      val_list [5];
        int                              i;
        idx_list = '{efd_pkg::REG_SYNC_VALUE, efd_pkg::REG_TYPE_SHORT_AC,
                     efd_pkg::REG_TYPE_SHORT_S, efd_pkg::REG_TYPE_LONG_S,
                     efd_pkg::REG_TYPE_STATUS};
        val_list = '{sync_v, ac_v, short_v, long_v, status_v};
        release_input();
        wait_drained();
        for (i = 0; i < 5; i++) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx_list[i];
            cfg_bus.data  <= val_list[i];
            do @(posedge i_clk); while (!cfg_bus.ready);
            set_register(idx_list[i], val_list[i]);
        end
        cfg_bus.valid <= 1'b0;
        settings_applied++;
    endtask

    // Body byte with random content, often the sync value (sent doubled)
    task automatic send_body_byte();
        logic [7:0] d;
        d = ($urandom_range(0, 5) == 0) ? reg_sync : 8'($urandom_range(0, 255));
        send_byte(d);
        if (d == reg_sync) send_byte(d);
    endtask

    // Frame of the given kind; optionally cut short or with a random type byte
    task automatic send_frame(input efd_pkg::t_kind kind, input bit truncate,
                              input bit bad_type);
        int len;
        int stop;
        int i;
        len  = body_length(kind);
        stop = truncate ? $urandom_range(0, len - 1) : len;
        send_byte(reg_sync);
        send_byte(bad_type ? 8'($urandom_range(0, 255)) : type_code_of(kind));
        for (i = 0; i < stop; i++) send_body_byte();
    endtask

    // Mostly well-formed frames, with aborts, bad types and line noise
    task automatic run_link_traffic(input int n_bytes);
        int stop_at;
        int pick;
        int i;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 15) == 0) begin
                sender_idle   = 1'($urandom_range(0, 1));
                receiver_idle = 1'($urandom_range(0, 1));
            end
            pick = $urandom_range(0, 15);
            if (pick < 11) begin
                send_frame(efd_pkg::t_kind'($urandom_range(0, 3)), 1'b0, 1'b0);
            end else if (pick < 13) begin
                send_frame(efd_pkg::t_kind'($urandom_range(0, 3)), 1'b1, 1'b0);
            end else if (pick < 14) begin
                send_frame(efd_pkg::t_kind'($urandom_range(0, 3)), 1'b0, 1'b1);
            end else begin
                for (i = 0; i < $urandom_range(1, 4); i++) begin
                    if ($urandom_range(0, 3) == 0) send_byte(reg_sync);
                    else send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // Special cases with the reset codes: hunt, escapes, aborts, bad types
    task automatic test_directed_cases();
        logic [7:0] s;
        logic [7:0] seq[$];
        int         i;
        s = reg_sync;
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        seq = '{8'h00, s, s, s, 8'h77,
                s, reg_code_ac, 8'h00, 8'hFF, s, s, 8'h80, 8'h01, 8'h7F, 8'h55,
                8'hAA, 8'hFE,
                s, s,
                s, reg_code_short_s, 8'h11, s, reg_code_long_s, 8'h44, s, 8'h99};
        for (i = 0; i < seq.size(); i++) send_byte(seq[i]);
    endtask

    task automatic test_default_traffic();
        run_link_traffic(600);
    endtask

    // Extreme and overlapping codes, including a type code equal to sync
    task automatic test_code_extremes();
        apply_codes(8'h00, 8'hFF, 8'h01, 8'hFF, 8'h80);
        run_link_traffic(300);
        apply_codes(8'hFF, 8'h00, 8'hFE, 8'h7F, 8'hFF);
        run_link_traffic(300);
    endtask

    // Random register settings; pause the sender once until fully drained
    task automatic test_random_codes();
        apply_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
        run_link_traffic(150);
        release_input();
        wait_drained();
        run_link_traffic(150);
        apply_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        run_link_traffic(300);
    endtask

    // Main sequence
    initial begin
        i_rst_n        <= 1'b0;
        in_bus.valid   <= 1'b0;
        in_bus.rx_byte <= 8'd0;
        cfg_bus.valid  <= 1'b0;
        cfg_bus.index  <= efd_pkg::REG_SYNC_VALUE;
        cfg_bus.data   <= 8'd0;
        in_valid_high    = 1'b0;
        next_gap         = 0;
        bytes_sent       = 0;
        mismatch_count   = 0;
        frames_done      = 0;
        error_events     = 0;
        settings_applied = 1;
        reset_predictor();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_default_traffic();
        test_code_extremes();
        test_random_codes();

        release_input();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (expected_q.size() != 0)
            report_mismatch("results never delivered", 32'(expected_q.size()), 32'd0);

        $display("Sent %0d link bytes under %0d register settings", bytes_sent,
                 settings_applied);
        $display("Checked %0d complete frames and %0d error events", frames_done,
                 error_events);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
